/* rtl/pgtcf_pkg.sv */
// Shared constants and types for the pixel gray/tone/color/flash pipeline.
// No dependencies; used by pgtcf_blend and pixel_gray_tone_color_flash.
`default_nettype none

package pgtcf_pkg;

    // channel width and full-scale value
    localparam int CHAN_BITS = 8;
    localparam int CHAN_MAX  = (1 << CHAN_BITS) - 1;

    // signed working width: holds -MAX .. 2*MAX with headroom
    localparam int SUM_W  = CHAN_BITS + 3;
    // signed product width of (b - a) * t
    localparam int PROD_W = SUM_W + CHAN_BITS;
    // quotient width, magnitude up to 2*MAX
    localparam int QUOT_W = CHAN_BITS + 1;

    // round-to-nearest offset: floor((m + ROUND) / MAX) rounds halves up
    localparam int ROUND = (CHAN_MAX - 1) / 2;

    // divide by MAX as multiply by a scaled reciprocal, exact for the product range
    localparam int RECIP_SHIFT = PROD_W + CHAN_BITS - 1;
    localparam longint RECIP   = ((longint'(1) << RECIP_SHIFT) + CHAN_MAX - 1) / CHAN_MAX;
    localparam int RECIP_W     = $clog2(RECIP + 1);

    // luma weights over 256
    localparam int LUMA_WR   = 77;
    localparam int LUMA_WG   = 150;
    localparam int LUMA_WB   = 29;
    localparam int LUMA_RND  = 128;
    localparam int LUMA_SH   = 8;
    localparam int LUMA_W    = CHAN_BITS + LUMA_SH + 1;

    // configuration register file
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TONE_W     = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TONE_RED   = 3'd0,
        CFG_TONE_GREEN = 3'd1,
        CFG_TONE_BLUE  = 3'd2,
        CFG_GRAY       = 3'd3,
        CFG_OPACITY    = 3'd4,
        CFG_COLOR      = 3'd5,
        CFG_FLASH      = 3'd6
    } t_cfg_idx;

    // stage enables of one blend unit
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_blend_en;

endpackage

`default_nettype wire

/* rtl/pixel_gray_tone_color_flash.sv */
// Top level of the pixel gray/tone/color/flash pipeline: config registers,
// luma stage, ten pgtcf_blend units, saturating output stage. Uses pgtcf_pkg.
//
// Usage:
//   Input channel: i_valid / o_ready with one RGBA texel per item.
//   Output channel: o_valid / i_ready with one adjusted RGBA pixel per item.
//   Config channel: i_cfg_valid / o_cfg_ready, i_cfg_index selects the
//   register (tone red/green/blue, gray amount, opacity, color word, flash
//   word), i_cfg_data carries the value; always ready. Write only while idle.
//   The path from input accept to output valid has eleven register stages
//   (one luma stage, three ranks of blend units of three stages each, one
//   saturating output register), the first loaded at the accept edge.
//   Throughput is one item per cycle unless stalled; each stage advances
//   when it is empty or the stage after it advances, so bubbles are squeezed out.
//   When the receiver stalls, the held result stays on the outputs and
//   upstream stages keep filling until every stage holds an item; only then
//   does o_ready drop. Nothing is lost or repeated.
//   Reset clears all stage valid bits and sets the registers to defaults:
//   opacity 255, everything else zero.
`default_nettype none

module pixel_gray_tone_color_flash (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input items
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [pgtcf_pkg::CHAN_BITS-1:0]     i_texel_red,
    input  wire logic [pgtcf_pkg::CHAN_BITS-1:0]     i_texel_green,
    input  wire logic [pgtcf_pkg::CHAN_BITS-1:0]     i_texel_blue,
    input  wire logic [pgtcf_pkg::CHAN_BITS-1:0]     i_texel_alpha,
    // output items
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [pgtcf_pkg::CHAN_BITS-1:0]          o_out_red,
    output logic [pgtcf_pkg::CHAN_BITS-1:0]          o_out_green,
    output logic [pgtcf_pkg::CHAN_BITS-1:0]          o_out_blue,
    output logic [pgtcf_pkg::CHAN_BITS-1:0]          o_out_alpha,
    // configuration writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [pgtcf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pgtcf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pgtcf_pkg::*;

    localparam int NSTG     = 11;
    localparam int ST_LUMA  = 0;
    localparam int ST_OUT   = NSTG - 1;
    localparam int ADLY_LO  = 4;
    localparam int ADLY_HI  = 9;

    // configuration registers
    logic signed [TONE_W-1:0] r_tone_red;
    logic signed [TONE_W-1:0] r_tone_green;
    logic signed [TONE_W-1:0] r_tone_blue;
    logic [CHAN_BITS-1:0]     r_gray;
    logic [CHAN_BITS-1:0]     r_opacity;
    logic [CFG_DATA_W-1:0]    r_color;
    logic [CFG_DATA_W-1:0]    r_flash;

    // pipeline control
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] en;

    // luma stage payload
    logic [LUMA_W-1:0]    n_luma_sum;
    logic [CHAN_BITS-1:0] r_luma;
    logic [CHAN_BITS-1:0] r_red0;
    logic [CHAN_BITS-1:0] r_green0;
    logic [CHAN_BITS-1:0] r_blue0;
    logic [CHAN_BITS-1:0] r_alpha0;

    // blend unit outputs
    logic signed [SUM_W-1:0] gray_red, gray_green, gray_blue;
    logic signed [SUM_W-1:0] col_red, col_green, col_blue;
    logic signed [SUM_W-1:0] fl_red, fl_green, fl_blue;
    logic signed [SUM_W-1:0] alpha_y;

    logic [CHAN_BITS-1:0] r_alpha_d [ADLY_LO:ADLY_HI];

    t_blend_en en_gray, en_col, en_fl;

    logic [CHAN_BITS-1:0] r_out_red, r_out_green, r_out_blue, r_out_alpha;

    // configuration write port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_red   <= '0;
            r_tone_green <= '0;
            r_tone_blue  <= '0;
            r_gray       <= '0;
            r_opacity    <= CHAN_BITS'(CHAN_MAX);
            r_color      <= '0;
            r_flash      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TONE_RED:   r_tone_red   <= $signed(i_cfg_data[TONE_W-1:0]);
                CFG_TONE_GREEN: r_tone_green <= $signed(i_cfg_data[TONE_W-1:0]);
                CFG_TONE_BLUE:  r_tone_blue  <= $signed(i_cfg_data[TONE_W-1:0]);
                CFG_GRAY:       r_gray       <= i_cfg_data[CHAN_BITS-1:0];
                CFG_OPACITY:    r_opacity    <= i_cfg_data[CHAN_BITS-1:0];
                CFG_COLOR:      r_color      <= i_cfg_data;
                CFG_FLASH:      r_flash      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables: a stage moves when empty or when its successor moves
    always_comb begin
        en[ST_OUT] = !r_v[ST_OUT] || i_ready;
        for (int k = ST_OUT - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[ST_LUMA];
    assign o_valid = r_v[ST_OUT];

    // valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[ST_LUMA]) begin
                r_v[ST_LUMA] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // luma stage
    always_comb begin
        n_luma_sum = LUMA_W'(LUMA_WR) * LUMA_W'(i_texel_red)
                   + LUMA_W'(LUMA_WG) * LUMA_W'(i_texel_green)
                   + LUMA_W'(LUMA_WB) * LUMA_W'(i_texel_blue)
                   + LUMA_W'(LUMA_RND);
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_LUMA]) begin
            r_luma   <= n_luma_sum[LUMA_SH +: CHAN_BITS];
            r_red0   <= i_texel_red;
            r_green0 <= i_texel_green;
            r_blue0  <= i_texel_blue;
            r_alpha0 <= i_texel_alpha;
        end
    end

    assign en_gray = '{s1: en[1], s2: en[2], s3: en[3]};
    assign en_col  = '{s1: en[4], s2: en[5], s3: en[6]};
    assign en_fl   = '{s1: en[7], s2: en[8], s3: en[9]};

    // gray blend with tone added at the end
    pgtcf_blend u_gray_red (
        .i_clk (i_clk), .i_en (en_gray),
        .i_a   ($signed({{(SUM_W - CHAN_BITS){1'b0}}, r_red0})),
        .i_b   (r_luma), .i_t (r_gray),
        .i_off (SUM_W'(r_tone_red)), .o_y (gray_red)
    );
    pgtcf_blend u_gray_green (
        .i_clk (i_clk), .i_en (en_gray),
        .i_a   ($signed({{(SUM_W - CHAN_BITS){1'b0}}, r_green0})),
        .i_b   (r_luma), .i_t (r_gray),
        .i_off (SUM_W'(r_tone_green)), .o_y (gray_green)
    );
    pgtcf_blend u_gray_blue (
        .i_clk (i_clk), .i_en (en_gray),
        .i_a   ($signed({{(SUM_W - CHAN_BITS){1'b0}}, r_blue0})),
        .i_b   (r_luma), .i_t (r_gray),
        .i_off (SUM_W'(r_tone_blue)), .o_y (gray_blue)
    );

    // alpha scale by opacity, same rounding as a blend from zero
    pgtcf_blend u_alpha (
        .i_clk (i_clk), .i_en (en_gray),
        .i_a   ('0), .i_b (r_alpha0), .i_t (r_opacity),
        .i_off ('0), .o_y (alpha_y)
    );

    // blend toward the color word
    pgtcf_blend u_col_red (
        .i_clk (i_clk), .i_en (en_col), .i_a (gray_red),
        .i_b   (r_color[7:0]), .i_t (r_color[31:24]),
        .i_off ('0), .o_y (col_red)
    );
    pgtcf_blend u_col_green (
        .i_clk (i_clk), .i_en (en_col), .i_a (gray_green),
        .i_b   (r_color[15:8]), .i_t (r_color[31:24]),
        .i_off ('0), .o_y (col_green)
    );
    pgtcf_blend u_col_blue (
        .i_clk (i_clk), .i_en (en_col), .i_a (gray_blue),
        .i_b   (r_color[23:16]), .i_t (r_color[31:24]),
        .i_off ('0), .o_y (col_blue)
    );

    // blend toward the flash word
    pgtcf_blend u_fl_red (
        .i_clk (i_clk), .i_en (en_fl), .i_a (col_red),
        .i_b   (r_flash[7:0]), .i_t (r_flash[31:24]),
        .i_off ('0), .o_y (fl_red)
    );
    pgtcf_blend u_fl_green (
        .i_clk (i_clk), .i_en (en_fl), .i_a (col_green),
        .i_b   (r_flash[15:8]), .i_t (r_flash[31:24]),
        .i_off ('0), .o_y (fl_green)
    );
    pgtcf_blend u_fl_blue (
        .i_clk (i_clk), .i_en (en_fl), .i_a (col_blue),
        .i_b   (r_flash[23:16]), .i_t (r_flash[31:24]),
        .i_off ('0), .o_y (fl_blue)
    );

    // alpha delay line alongside the color and flash blends
    always_ff @(posedge i_clk) begin
        if (en[ADLY_LO]) begin
            r_alpha_d[ADLY_LO] <= alpha_y[CHAN_BITS-1:0];
        end
        for (int k = ADLY_LO + 1; k <= ADLY_HI; k++) begin
            if (en[k]) begin
                r_alpha_d[k] <= r_alpha_d[k-1];
            end
        end
    end

    // saturate to 0..MAX
    function automatic logic [CHAN_BITS-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic [CHAN_BITS-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > SUM_W'(CHAN_MAX)) begin
            res = CHAN_BITS'(CHAN_MAX);
        end else begin
            res = v[CHAN_BITS-1:0];
        end
        return res;
    endfunction

    // output register
    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_out_red   <= sat(fl_red);
            r_out_green <= sat(fl_green);
            r_out_blue  <= sat(fl_blue);
            r_out_alpha <= r_alpha_d[ADLY_HI];
        end
    end

    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_out_alpha = r_out_alpha;

endmodule

`default_nettype wire

/* rtl/pgtcf_blend.sv */
// Three-stage blend unit: y = a + round((b - a) * t / MAX) + off.
// Depends on pgtcf_pkg for widths, rounding and reciprocal constants.
`default_nettype none

module pgtcf_blend (
    input  wire logic                               i_clk,
    input  wire pgtcf_pkg::t_blend_en               i_en,
    input  wire logic signed [pgtcf_pkg::SUM_W-1:0] i_a,
    input  wire logic [pgtcf_pkg::CHAN_BITS-1:0]    i_b,
    input  wire logic [pgtcf_pkg::CHAN_BITS-1:0]    i_t,
    input  wire logic signed [pgtcf_pkg::SUM_W-1:0] i_off,
    output logic signed [pgtcf_pkg::SUM_W-1:0]      o_y
);
    import pgtcf_pkg::*;

    localparam int MAG_W = PROD_W - 1;
    localparam int MUL_W = MAG_W + RECIP_W;

    logic signed [SUM_W-1:0]  n_diff;
    logic signed [PROD_W-1:0] n_p;
    logic signed [PROD_W-1:0] r_p;
    logic signed [SUM_W-1:0]  r_a1;
    logic signed [PROD_W-1:0] n_abs;
    logic [MAG_W-1:0]         n_m;
    logic [MUL_W-1:0]         n_prod;
    logic [QUOT_W-1:0]        r_q;
    logic                     r_neg;
    logic signed [SUM_W-1:0]  r_a2;
    logic signed [SUM_W-1:0]  n_qs;
    logic signed [SUM_W-1:0]  r_y;

    // stage 1: difference times weight
    always_comb begin
        n_diff = $signed({{(SUM_W - CHAN_BITS){1'b0}}, i_b}) - i_a;
        n_p    = PROD_W'(n_diff) * PROD_W'($signed({1'b0, i_t}));
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_p  <= n_p;
            r_a1 <= i_a;
        end
    end

    // stage 2: magnitude plus rounding, divide by MAX through the reciprocal
    always_comb begin
        n_abs  = r_p[PROD_W-1] ? -r_p : r_p;
        n_m    = n_abs[MAG_W-1:0] + MAG_W'(ROUND);
        n_prod = MUL_W'(n_m) * MUL_W'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_q   <= n_prod[RECIP_SHIFT +: QUOT_W];
            r_neg <= r_p[PROD_W-1];
            r_a2  <= r_a1;
        end
    end

    // stage 3: apply signed quotient and offset
    always_comb begin
        n_qs = $signed({{(SUM_W - QUOT_W){1'b0}}, r_q});
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_y <= r_a2 + (r_neg ? -n_qs : n_qs) + i_off;
        end
    end

    assign o_y = r_y;

endmodule

`default_nettype wire
